// ===== design/free_run_extractor_top_macros.svh =====
// Assertion helpers used by the top level to check itself.
`ifndef FREE_RUN_EXTRACTOR_TOP_MACROS_SVH
`define FREE_RUN_EXTRACTOR_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FRE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define FRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== design/fre_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fre_pkg;

  localparam int BITS_PER_ITEM = 8;
  localparam int MAX_EVENTS    = 5;
  localparam int OFF_W         = 3;
  localparam int LEN_W         = 4;
  localparam int NV_W          = 4;
  localparam int EV_CNT_W      = 3;
  localparam int QUEUE_DEPTH   = 4;
  localparam int PTR_W         = 2;
  localparam int QCNT_W        = 3;

  // One free run as seen inside a byte: merge means it extends the open run.
  typedef struct packed {
    logic             merge;
    logic [OFF_W-1:0] offset;
    logic [LEN_W-1:0] len;
  } run_desc_t;

  typedef struct packed {
    run_desc_t [MAX_EVENTS-1:0] ev;
    logic [EV_CNT_W-1:0]        ev_cnt;
    logic                       tail_open;
    run_desc_t                  tail;
    logic [NV_W-1:0]            nvalid;
    logic                       eom;
  } item_desc_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } fq_status_t;

  typedef struct packed {
    logic emit;
    logic pop;
  } bk_status_t;

endpackage

`default_nettype wire

// ===== design/fre_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fre_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [fre_pkg::BITS_PER_ITEM-1:0] in_map_byte,
  input  wire logic [fre_pkg::NV_W-1:0]       in_valid_bits,
  input  wire logic                           in_end_of_map,
  input  wire fre_pkg::fq_status_t            q_status,
  output      logic                           q_push,
  output      fre_pkg::item_desc_t            q_data
);

  logic                          open_r;
  logic                          open_nxt;
  logic [fre_pkg::NV_W-1:0]      nv_c;
  logic                          open_c;
  fre_pkg::run_desc_t            cur_c;
  logic [fre_pkg::EV_CNT_W-1:0]  cnt_c;
  fre_pkg::item_desc_t           desc_c;

  assign in_ready = !q_status.full;
  assign q_push   = in_valid && in_ready;
  assign q_data   = desc_c;

  // Split the byte into closed runs plus the run left open at its end.
  always_comb begin
    nv_c = (in_valid_bits > fre_pkg::NV_W'(fre_pkg::BITS_PER_ITEM)) ?
           fre_pkg::NV_W'(fre_pkg::BITS_PER_ITEM) : in_valid_bits;
    desc_c       = '0;
    open_c       = open_r;
    cur_c        = '0;
    cur_c.merge  = open_r;
    cnt_c        = '0;
    for (int i = 0; i < fre_pkg::BITS_PER_ITEM; i++) begin
      if (fre_pkg::NV_W'(i) < nv_c) begin
        if (!in_map_byte[i]) begin
          if (!open_c) begin
            open_c       = 1'b1;
            cur_c.merge  = 1'b0;
            cur_c.offset = fre_pkg::OFF_W'(i);
            cur_c.len    = fre_pkg::LEN_W'(1);
          end else begin
            cur_c.len = cur_c.len + fre_pkg::LEN_W'(1);
          end
        end else if (open_c) begin
          desc_c.ev[cnt_c] = cur_c;
          cnt_c            = cnt_c + fre_pkg::EV_CNT_W'(1);
          open_c           = 1'b0;
        end
      end
    end
    if (in_end_of_map && open_c) begin
      desc_c.ev[cnt_c] = cur_c;
      cnt_c            = cnt_c + fre_pkg::EV_CNT_W'(1);
      open_c           = 1'b0;
    end
    desc_c.ev_cnt    = cnt_c;
    desc_c.tail_open = open_c;
    desc_c.tail      = cur_c;
    desc_c.nvalid    = nv_c;
    desc_c.eom       = in_end_of_map;
  end

  assign open_nxt = q_push ? desc_c.tail_open : open_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fre_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fre_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire fre_pkg::item_desc_t push_data,
  input  wire fre_pkg::bk_status_t bk_status,
  output      fre_pkg::fq_status_t status,
  output      fre_pkg::item_desc_t head
);

  fre_pkg::item_desc_t              mem_r [fre_pkg::QUEUE_DEPTH];
  logic [fre_pkg::PTR_W-1:0]        wr_ptr_r;
  logic [fre_pkg::PTR_W-1:0]        wr_ptr_nxt;
  logic [fre_pkg::PTR_W-1:0]        rd_ptr_r;
  logic [fre_pkg::PTR_W-1:0]        rd_ptr_nxt;
  logic [fre_pkg::QCNT_W-1:0]       count_r;
  logic [fre_pkg::QCNT_W-1:0]       count_nxt;

  assign status.full      = count_r == fre_pkg::QCNT_W'(fre_pkg::QUEUE_DEPTH);
  assign status.not_empty = count_r != '0;
  assign head             = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + fre_pkg::PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = bk_status.pop ? rd_ptr_r + fre_pkg::PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !bk_status.pop) begin
      count_nxt = count_r + fre_pkg::QCNT_W'(1);
    end else if (!push && bk_status.pop) begin
      count_nxt = count_r - fre_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/fre_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fre_back #(
  parameter int CLUSTER_BITS = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CLUSTER_BITS-1:0] cfg_wr_data,
  input  wire fre_pkg::fq_status_t     q_status,
  input  wire fre_pkg::item_desc_t     q_head,
  output      fre_pkg::bk_status_t     status,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [CLUSTER_BITS-1:0] out_run_start,
  output      logic [CLUSTER_BITS-1:0] out_run_length,
  output      logic                    out_last_of_item
);

  localparam int SUM_W = CLUSTER_BITS + 2;
  localparam logic [CLUSTER_BITS-1:0] CL_MAX = '1;
  localparam logic [SUM_W-1:0] SUM_MAX = {2'b00, CL_MAX};

  logic [CLUSTER_BITS-1:0]      start_cluster_r;
  logic [CLUSTER_BITS-1:0]      pos_r;
  logic [CLUSTER_BITS-1:0]      pos_nxt;
  logic [CLUSTER_BITS-1:0]      open_start_r;
  logic [CLUSTER_BITS-1:0]      open_start_nxt;
  logic [CLUSTER_BITS-1:0]      open_len_r;
  logic [CLUSTER_BITS-1:0]      open_len_nxt;
  logic [fre_pkg::EV_CNT_W-1:0] idx_r;
  logic [fre_pkg::EV_CNT_W-1:0] idx_nxt;
  logic [fre_pkg::EV_CNT_W-1:0] idx_inc;
  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [CLUSTER_BITS-1:0]      run_start_r;
  logic [CLUSTER_BITS-1:0]      run_length_r;
  logic                         last_r;

  fre_pkg::run_desc_t           ev;
  logic                         emitting;
  logic                         slot_free;
  logic                         step;
  logic                         last_ev;
  logic                         finish;
  logic [SUM_W-1:0]             ev_start_sum;
  logic [SUM_W-1:0]             ev_len_sum;
  logic [SUM_W-1:0]             tail_start_sum;
  logic [SUM_W-1:0]             tail_len_sum;
  logic [SUM_W-1:0]             pos_sum;
  logic [CLUSTER_BITS-1:0]      ev_start;
  logic [CLUSTER_BITS-1:0]      ev_len;
  logic [CLUSTER_BITS-1:0]      tail_start;
  logic [CLUSTER_BITS-1:0]      tail_len;

  assign ev        = q_head.ev[idx_r];
  assign idx_inc   = idx_r + fre_pkg::EV_CNT_W'(1);
  assign emitting  = q_status.not_empty && (idx_r < q_head.ev_cnt);
  assign slot_free = !out_valid_r || out_ready;
  assign step      = q_status.not_empty && (!emitting || slot_free);
  assign last_ev   = idx_inc == q_head.ev_cnt;
  assign finish    = step && (!emitting || last_ev);

  assign status.emit = step && emitting;
  assign status.pop  = finish;

  // Cluster numbers and lengths clamp at the all-ones value.
  always_comb begin
    ev_start_sum   = {2'b00, start_cluster_r} + {2'b00, pos_r} + SUM_W'(ev.offset);
    ev_len_sum     = {2'b00, open_len_r} + SUM_W'(ev.len);
    tail_start_sum = {2'b00, start_cluster_r} + {2'b00, pos_r}
                   + SUM_W'(q_head.tail.offset);
    tail_len_sum   = {2'b00, open_len_r} + SUM_W'(q_head.tail.len);
    pos_sum        = {2'b00, pos_r} + SUM_W'(q_head.nvalid);

    if (ev.merge) begin
      ev_start = open_start_r;
      ev_len   = (ev_len_sum > SUM_MAX) ? CL_MAX : ev_len_sum[CLUSTER_BITS-1:0];
    end else begin
      ev_start = (ev_start_sum > SUM_MAX) ? CL_MAX : ev_start_sum[CLUSTER_BITS-1:0];
      ev_len   = CLUSTER_BITS'(ev.len);
    end

    if (q_head.tail.merge) begin
      tail_start = open_start_r;
      tail_len   = (tail_len_sum > SUM_MAX) ? CL_MAX : tail_len_sum[CLUSTER_BITS-1:0];
    end else begin
      tail_start = (tail_start_sum > SUM_MAX) ? CL_MAX
                                              : tail_start_sum[CLUSTER_BITS-1:0];
      tail_len   = CLUSTER_BITS'(q_head.tail.len);
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    open_start_nxt = open_start_r;
    open_len_nxt   = open_len_r;
    idx_nxt        = idx_r;
    if (finish) begin
      idx_nxt = '0;
      if (q_head.eom) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = (pos_sum > SUM_MAX) ? CL_MAX : pos_sum[CLUSTER_BITS-1:0];
      end
      if (q_head.tail_open) begin
        open_start_nxt = tail_start;
        open_len_nxt   = tail_len;
      end
    end else if (step) begin
      idx_nxt = idx_inc;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (status.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_cluster_r <= '0;
      pos_r           <= '0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_cluster_r <= cfg_wr_data;
      end
      pos_r       <= pos_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    open_start_r <= open_start_nxt;
    open_len_r   <= open_len_nxt;
    if (status.emit) begin
      run_start_r  <= ev_start;
      run_length_r <= ev_len;
      last_r       <= last_ev;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_run_start    = run_start_r;
  assign out_run_length   = run_length_r;
  assign out_last_of_item = last_r;

endmodule

`default_nettype wire

// ===== design/free_run_extractor_top.sv =====
// Free run extractor: scans an allocation bitmap and reports each maximal
// run of free (clear) clusters as a start cluster and a length.
// Input channel (in_valid/in_ready): one bitmap byte per transfer, bit 0
// first, with in_valid_bits meaningful low bits (values above 8 count as 8)
// and in_end_of_map on the last byte, which closes any open run and starts
// the next map at start_cluster again.
// Output channel (out_valid/out_ready): one run per transfer; the last run
// caused by a byte carries out_last_of_item. A byte may cause zero to five
// runs; runs that span bytes are merged and reported once.
// cfg_wr_en/cfg_wr_data write start_cluster; write only while idle.
// Throughput: the back end emits one run per cycle while the receiver
// accepts them; the front end classifies one byte per cycle while the
// queue has room; a four-entry queue absorbs bursts of multi-run bytes.
// A closing byte is first stored in the queue; its run is then loaded
// into the output register that drives out_run_start and out_run_length.
// Reset clears the position, the open run, start_cluster and the queue.
// When the receiver stalls, the output register holds its run, the queue
// fills and in_ready drops once it is full.
`timescale 1ns / 1ps
`default_nettype none
`include "free_run_extractor_top_macros.svh"

module free_run_extractor_top #(
  parameter int CLUSTER_BITS = 48
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [CLUSTER_BITS-1:0]           cfg_wr_data,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [fre_pkg::BITS_PER_ITEM-1:0] in_map_byte,
  input  wire logic [fre_pkg::NV_W-1:0]          in_valid_bits,
  input  wire logic                              in_end_of_map,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [CLUSTER_BITS-1:0]           out_run_start,
  output      logic [CLUSTER_BITS-1:0]           out_run_length,
  output      logic                              out_last_of_item
);

  fre_pkg::fq_status_t q_status;
  fre_pkg::bk_status_t bk_status;
  fre_pkg::item_desc_t push_data;
  fre_pkg::item_desc_t q_head;
  logic                q_push;

  fre_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_map_byte   (in_map_byte),
    .in_valid_bits (in_valid_bits),
    .in_end_of_map (in_end_of_map),
    .q_status      (q_status),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  fre_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .bk_status (bk_status),
    .status    (q_status),
    .head      (q_head)
  );

  fre_back #(
    .CLUSTER_BITS (CLUSTER_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_status         (q_status),
    .q_head           (q_head),
    .status           (bk_status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_run_start    (out_run_start),
    .out_run_length   (out_run_length),
    .out_last_of_item (out_last_of_item)
  );

  `FRE_ASSERT_IMP(a_no_push_when_full, clk, rst_n, q_push, !q_status.full)
  `FRE_ASSERT_IMP(a_pop_needs_entry, clk, rst_n, bk_status.pop, q_status.not_empty)
  `FRE_ASSERT_IMP(a_emit_into_free_slot, clk, rst_n, bk_status.emit, !out_valid || out_ready)
  `FRE_ASSERT_NEXT(a_emit_shows_valid, clk, rst_n, bk_status.emit, out_valid)

endmodule

`default_nettype wire
